FILE: hdl/ascm_pkg.sv
// ---------------------------------------------------------------------------
// Allocation size-class mapper package
// Widths, band constants, the pipeline item type and per-stage functions.
// ---------------------------------------------------------------------------
`default_nettype none

package ascm_pkg;

  localparam int unsigned MAX_SIZE_BYTES  = 262144;
  localparam int unsigned PAGE_SHIFT_BITS = 13;

  localparam int unsigned SIZE_W  = 19;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned BATCH_W = 10;
  localparam int unsigned PAGE_W  = 7;
  localparam int unsigned QUO_W   = 9;
  localparam int unsigned QBIT_W  = $clog2(QUO_W);
  localparam int unsigned PROD_W  = SIZE_W + BATCH_W;
  localparam int unsigned TRIAL_W = SIZE_W + QUO_W - 1;

  localparam int unsigned BAND0_LIMIT = 128;
  localparam int unsigned BAND1_LIMIT = 1024;
  localparam int unsigned BAND2_LIMIT = 8 * 1024;
  localparam int unsigned BAND3_LIMIT = 64 * 1024;

  localparam int unsigned BATCH_MAX = 512;
  localparam int unsigned BATCH_MIN = 2;
  localparam int unsigned PAGE_MAX  = 127;

  // Input capture, one stage per quotient bit, then batch/multiply.
  localparam int unsigned NUM_STAGES = QUO_W + 2;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic               err;
    logic [SIZE_W-1:0]  rounded;
    logic [IDX_W-1:0]   idx;
    logic [SIZE_W-1:0]  rem;
    logic [QUO_W-1:0]   quo;
    logic [BATCH_W-1:0] batch;
    logic [PROD_W-1:0]  prod;
  } ascm_item_t;

  // Band lookup: alignment rounding and dense class index, divider seed.
  function automatic ascm_item_t classify(logic [SIZE_W-1:0] size);
    ascm_item_t        o;
    logic [SIZE_W-1:0] r;
    logic [IDX_W-1:0]  ix;
    o        = '0;
    o.size   = size;
    o.err    = (size == '0) || (size > SIZE_W'(MAX_SIZE_BYTES));
    o.rem    = SIZE_W'(MAX_SIZE_BYTES);
    if (size <= SIZE_W'(BAND0_LIMIT)) begin
      r  = (size + SIZE_W'(7)) & ~SIZE_W'(7);
      ix = IDX_W'(r >> 3) - IDX_W'(1);
    end else if (size <= SIZE_W'(BAND1_LIMIT)) begin
      r  = (size + SIZE_W'(15)) & ~SIZE_W'(15);
      ix = IDX_W'(r >> 4) + IDX_W'(7);
    end else if (size <= SIZE_W'(BAND2_LIMIT)) begin
      r  = (size + SIZE_W'(127)) & ~SIZE_W'(127);
      ix = IDX_W'(r >> 7) + IDX_W'(63);
    end else if (size <= SIZE_W'(BAND3_LIMIT)) begin
      r  = (size + SIZE_W'(1023)) & ~SIZE_W'(1023);
      ix = IDX_W'(r >> 10) + IDX_W'(119);
    end else begin
      r  = (size + SIZE_W'(8191)) & ~SIZE_W'(8191);
      ix = IDX_W'(r >> 13) + IDX_W'(175);
    end
    o.rounded = r;
    o.idx     = ix;
    return o;
  endfunction

  // One restoring division step: resolve quotient bit qbit.
  function automatic ascm_item_t div_step(ascm_item_t p, logic [QBIT_W-1:0] qbit);
    ascm_item_t         o;
    logic [TRIAL_W-1:0] trial;
    o     = p;
    trial = TRIAL_W'(p.size) << qbit;
    if (TRIAL_W'(p.rem) >= trial) begin
      o.rem       = p.rem - trial[SIZE_W-1:0];
      o.quo[qbit] = 1'b1;
    end
    return o;
  endfunction

  // Clamp the quotient to the batch range.
  function automatic logic [BATCH_W-1:0] clamp_batch(ascm_item_t p);
    logic [BATCH_W-1:0] b;
    priority if (p.size <= SIZE_W'(BATCH_MAX)) begin
      b = BATCH_W'(BATCH_MAX);
    end else if (p.quo < QUO_W'(BATCH_MIN)) begin
      b = BATCH_W'(BATCH_MIN);
    end else begin
      b = BATCH_W'(p.quo);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/alloc_size_class_mapper.sv
// Each request passes the input stage, the divider stages and the multiply stage, then the output register.
// Throughput: one request per cycle unless the result side stalls; the restoring divider
// resolves one quotient bit per stage over 9 stages, followed by a multiply stage.
// A stall on the result side holds every stage in place.
// Reset (rst_ni low) clears all stage valid bits; payloads are not reset.
// ---------------------------------------------------------------------------
// Allocation size-class mapper
// Maps a request size to rounded size, class index, batch and page counts.
// ---------------------------------------------------------------------------
`default_nettype none

module alloc_size_class_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [18:0] request_size, [23:19] zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [18:0] rounded_size, [26:19] class_index, [36:27] batch_count,
  // [43:37] page_count, [47:44] zero
  output logic [47:0]      m_axis_tdata_o,
  output logic [0:0]       m_axis_tuser_o   // [0] size_error
);

  localparam int unsigned NSTG = ascm_pkg::NUM_STAGES;
  localparam int unsigned LAST = NSTG - 1;

  ascm_pkg::ascm_item_t st_d [NSTG];
  ascm_pkg::ascm_item_t st_q [NSTG];
  logic [NSTG-1:0]      vld_q;

  logic                                  out_vld_q;
  logic [ascm_pkg::SIZE_W-1:0]           out_rounded_q;
  logic [ascm_pkg::IDX_W-1:0]            out_idx_q;
  logic [ascm_pkg::BATCH_W-1:0]          out_batch_q;
  logic [ascm_pkg::PAGE_W-1:0]           out_pages_q;
  logic                                  out_err_q;

  logic [ascm_pkg::PAGE_W-1:0]           pages_d;
  logic [ascm_pkg::PROD_W-1:0]           pages_raw;
  logic                                  adv;

  // Whole pipeline moves when the output register is free or drained.
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    st_d[0]      = '0;
    st_d[0].size = s_axis_tdata_i[ascm_pkg::SIZE_W-1:0];
  end

  for (genvar j = 1; j <= ascm_pkg::QUO_W; j++) begin : g_div
    if (j == 1) begin : g_first
      always_comb begin
        st_d[j] = ascm_pkg::div_step(ascm_pkg::classify(st_q[0].size),
                                     ascm_pkg::QBIT_W'(ascm_pkg::QUO_W - j));
      end
    end else begin : g_rest
      always_comb begin
        st_d[j] = ascm_pkg::div_step(st_q[j-1],
                                     ascm_pkg::QBIT_W'(ascm_pkg::QUO_W - j));
      end
    end
  end

  always_comb begin
    st_d[LAST]       = st_q[LAST-1];
    st_d[LAST].batch = ascm_pkg::clamp_batch(st_q[LAST-1]);
    st_d[LAST].prod  = ascm_pkg::PROD_W'(st_d[LAST].batch) *
                       ascm_pkg::PROD_W'(st_q[LAST-1].size);
  end

  // Pages from the registered product: shift, then clamp to 1..127.
  always_comb begin
    pages_raw = st_q[LAST].prod >> ascm_pkg::PAGE_SHIFT_BITS;
    priority if (pages_raw == '0) begin
      pages_d = ascm_pkg::PAGE_W'(1);
    end else if (pages_raw > ascm_pkg::PROD_W'(ascm_pkg::PAGE_MAX)) begin
      pages_d = ascm_pkg::PAGE_W'(ascm_pkg::PAGE_MAX);
    end else begin
      pages_d = pages_raw[ascm_pkg::PAGE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned k = 0; k < NSTG; k++) begin
        st_q[k] <= st_d[k];
      end
      // Drop all data fields to zero on an error request.
      out_err_q     <= st_q[LAST].err;
      out_rounded_q <= st_q[LAST].err ? '0 : st_q[LAST].rounded;
      out_idx_q     <= st_q[LAST].err ? '0 : st_q[LAST].idx;
      out_batch_q   <= st_q[LAST].err ? '0 : st_q[LAST].batch;
      out_pages_q   <= st_q[LAST].err ? '0 : pages_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSTG-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[LAST];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, out_pages_q, out_batch_q, out_idx_q, out_rounded_q};
  assign m_axis_tuser_o  = out_err_q;

  // Error results carry all-zero data.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_err_q |-> m_axis_tdata_o == '0)
    else $error("error result with nonzero data");

  // Good results keep batch and page counts inside their clamp ranges and a nonzero rounded size.
  a_good_ranges : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_err_q |->
      out_batch_q >= ascm_pkg::BATCH_W'(ascm_pkg::BATCH_MIN) &&
      out_batch_q <= ascm_pkg::BATCH_W'(ascm_pkg::BATCH_MAX) &&
      out_pages_q != '0 && out_rounded_q != '0)
    else $error("batch or page count out of range");

  // Class index never exceeds the last class.
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_idx_q <= ascm_pkg::IDX_W'(207))
    else $error("class index out of range");

  // A stalled pipeline keeps every stage valid bit.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> $stable(vld_q) && out_vld_q)
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
